/* hdl/i2cm_pkg.sv */
// Shared types, constants and helper functions for the I2C register access master.
// Depends on nothing; every other file in this block uses it.

package i2cm_pkg;

   // Reset values of the control registers.
   localparam logic [7:0] ACK_TIMEOUT_RESET   = 8'd250;
   localparam logic [1:0] ADDRESS_BYTES_RESET = 2'd2;

   // Control register indexes on the csr port.
   localparam int         CSR_INDEX_W       = 8;
   localparam int         CSR_DATA_W        = 8;
   localparam logic [7:0] CSR_ACK_TIMEOUT   = 8'd0;
   localparam logic [7:0] CSR_ADDRESS_BYTES = 8'd1;

   // Depth of the request queue between the front and the sequencer.
   localparam int QUEUE_DEPTH = 4;

   // Byte index markers for the two received bytes.
   localparam logic [2:0] RX_FIRST  = 3'd6;
   localparam logic [2:0] RX_SECOND = 3'd7;

   // Number of bits in one byte on the bus.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Request classes decided by the front.
   typedef enum logic {
      ITEM_COMMAND = 1'b0,
      ITEM_TICK    = 1'b1
   } item_class_type;

   // Bus phases of the sequencer.
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START    = 4'd1,
      PH_SEND     = 4'd2,
      PH_SACK     = 4'd3,
      PH_RSTART   = 4'd4,
      PH_RECV     = 4'd5,
      PH_MACK     = 4'd6,
      PH_STOP     = 4'd7,
      PH_STOP_ERR = 4'd8
   } phase_type;

   // One queued request.
   typedef struct packed {
      item_class_type item_class;
      logic [1:0]     operation;
      logic [6:0]     device_address;
      logic [15:0]    register_address;
      logic [15:0]    write_data;
      logic           sda_in;
   } queue_entry_type;

   // One result as it leaves the sequencer.
   typedef struct packed {
      logic        scl;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic        nack_error;
      logic [15:0] read_data;
   } result_type;

   // Number of register address bytes sent: 2 when two_addr is set, else 1.
   function automatic logic [2:0] addr_count(input logic two_addr);
      return two_addr ? 3'd2 : 3'd1;
   endfunction

   // Byte transmitted at position k of the outgoing sequence.
   function automatic logic [7:0] tx_byte(
      input logic [2:0]  k,
      input logic        two_addr,
      input logic [1:0]  operation,
      input logic [6:0]  device_address,
      input logic [15:0] register_address,
      input logic [15:0] write_data
   );
      logic [2:0] na;
      logic [7:0] result;
      na = addr_count(two_addr);
      if (k == 3'd0) begin
         result = {device_address, 1'b0};
      end else if (k <= na) begin
         result = (two_addr && (k == 3'd1)) ? register_address[15:8]
                                            : register_address[7:0];
      end else if (operation[1]) begin
         result = {device_address, 1'b1};
      end else if (operation[0] && (k == na + 3'd1)) begin
         result = write_data[15:8];
      end else begin
         result = write_data[7:0];
      end
      return result;
   endfunction

endpackage

/* hdl/i2cm_front.sv */
// Front end of the I2C register access master: accepts requests, classifies
// them and holds them in a short queue for the sequencer. Uses i2cm_pkg.

module i2cm_front #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [1:0]                req_operation,
   input  logic [6:0]                req_device_address,
   input  logic [15:0]               req_register_address,
   input  logic [15:0]               req_write_data,
   input  logic                      req_sda_in,
   output logic                      entry_valid,
   input  logic                      entry_pop,
   output i2cm_pkg::queue_entry_type entry
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   i2cm_pkg::queue_entry_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   i2cm_pkg::queue_entry_type incoming;
   logic                      push;
   logic                      pop;

   // Classify the incoming request and pack it for the queue.
   always_comb begin
      incoming.item_class       = req_kind ? i2cm_pkg::ITEM_TICK : i2cm_pkg::ITEM_COMMAND;
      incoming.operation        = req_operation;
      incoming.device_address   = req_device_address;
      incoming.register_address = req_register_address;
      incoming.write_data       = req_write_data;
      incoming.sda_in           = req_sda_in;
   end

   assign req_ready   = (count_ff != FULL_COUNT);
   assign push        = req_valid && req_ready;
   assign entry_valid = (count_ff != '0);
   assign pop         = entry_pop && entry_valid;
   assign entry       = queue_ff[head_ff];

   // Pointer and fill count updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= incoming;
      end
   end

endmodule

/* hdl/i2cm_back.sv */
// Back end of the I2C register access master: the bus phase sequencer, the
// control registers and the result register. Uses i2cm_pkg.

module i2cm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      entry_valid,
   output logic                      entry_pop,
   input  i2cm_pkg::queue_entry_type entry,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_index,
   input  logic [7:0]                csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output i2cm_pkg::result_type      result
);

   // Control registers.
   logic [7:0] ack_timeout_ff;
   logic [1:0] address_bytes_ff;

   // Sequencer state.
   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic [15:0] read_accum_ff, read_accum_in;
   logic [1:0]  operation_ff, operation_in;
   logic [6:0]  device_ff, device_in;
   logic [15:0] register_ff, register_in;
   logic [15:0] data_ff, data_in;

   // Result register.
   logic                 rsp_valid_ff;
   i2cm_pkg::result_type result_ff, result_in;

   logic       step;
   logic       is_tick;
   logic       two_addr;
   logic       is_read;
   logic [2:0] na;
   logic [2:0] nd;
   logic [3:0] bit_next;
   logic [7:0] recv_shift;

   assign csr_ready = 1'b1;
   assign step      = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign entry_pop = step;
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   assign is_tick    = (entry.item_class == i2cm_pkg::ITEM_TICK);
   assign two_addr   = address_bytes_ff[1];
   assign is_read    = operation_ff[1];
   assign na         = i2cm_pkg::addr_count(two_addr);
   assign nd         = operation_ff[0] ? 3'd2 : 3'd1;
   assign bit_next   = bit_count_ff + 4'd1;
   assign recv_shift = {shift_ff[6:0], entry.sda_in};

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff   <= i2cm_pkg::ACK_TIMEOUT_RESET;
         address_bytes_ff <= i2cm_pkg::ADDRESS_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == i2cm_pkg::CSR_ACK_TIMEOUT) begin
            ack_timeout_ff <= csr_data;
         end else if (csr_index == i2cm_pkg::CSR_ADDRESS_BYTES) begin
            address_bytes_ff <= csr_data[1:0];
         end
      end
   end

   // Next state of the sequencer for the item at the head of the queue.
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      byte_index_in = byte_index_ff;
      shift_in      = shift_ff;
      timeout_in    = timeout_ff;
      read_accum_in = read_accum_ff;
      operation_in  = operation_ff;
      device_in     = device_ff;
      register_in   = register_ff;
      data_in       = data_ff;
      if (!is_tick) begin
         // A command starts a transaction only when the bus is idle.
         if (phase_ff == i2cm_pkg::PH_IDLE) begin
            operation_in  = entry.operation;
            device_in     = entry.device_address;
            register_in   = entry.register_address;
            data_in       = entry.write_data;
            bit_count_in  = '0;
            byte_index_in = '0;
            shift_in      = '0;
            timeout_in    = '0;
            read_accum_in = '0;
            phase_in      = i2cm_pkg::PH_START;
         end
      end else begin
         case (phase_ff)
            i2cm_pkg::PH_START: begin
               byte_index_in = '0;
               shift_in      = i2cm_pkg::tx_byte(3'd0, two_addr, operation_ff,
                                                 device_ff, register_ff, data_ff);
               bit_count_in  = '0;
               phase_in      = i2cm_pkg::PH_SEND;
            end
            i2cm_pkg::PH_SEND: begin
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_next;
               if (bit_next >= i2cm_pkg::BITS_PER_BYTE) begin
                  timeout_in = '0;
                  phase_in   = i2cm_pkg::PH_SACK;
               end
            end
            i2cm_pkg::PH_SACK: begin
               if (entry.sda_in) begin
                  // Target has not acknowledged yet: count or give up.
                  if (timeout_ff >= ack_timeout_ff) begin
                     phase_in = i2cm_pkg::PH_STOP_ERR;
                  end else begin
                     timeout_in = timeout_ff + 8'd1;
                  end
               end else if (is_read) begin
                  if (byte_index_ff < na) begin
                     byte_index_in = byte_index_ff + 3'd1;
                     shift_in      = i2cm_pkg::tx_byte(byte_index_ff + 3'd1, two_addr,
                                                       operation_ff, device_ff,
                                                       register_ff, data_ff);
                     bit_count_in  = '0;
                     phase_in      = i2cm_pkg::PH_SEND;
                  end else if (byte_index_ff == na) begin
                     phase_in = i2cm_pkg::PH_RSTART;
                  end else begin
                     byte_index_in = i2cm_pkg::RX_FIRST;
                     bit_count_in  = '0;
                     shift_in      = '0;
                     phase_in      = i2cm_pkg::PH_RECV;
                  end
               end else begin
                  if (byte_index_ff < na + nd) begin
                     byte_index_in = byte_index_ff + 3'd1;
                     shift_in      = i2cm_pkg::tx_byte(byte_index_ff + 3'd1, two_addr,
                                                       operation_ff, device_ff,
                                                       register_ff, data_ff);
                     bit_count_in  = '0;
                     phase_in      = i2cm_pkg::PH_SEND;
                  end else begin
                     phase_in = i2cm_pkg::PH_STOP;
                  end
               end
            end
            i2cm_pkg::PH_RSTART: begin
               byte_index_in = na + 3'd1;
               shift_in      = i2cm_pkg::tx_byte(na + 3'd1, two_addr, operation_ff,
                                                 device_ff, register_ff, data_ff);
               bit_count_in  = '0;
               phase_in      = i2cm_pkg::PH_SEND;
            end
            i2cm_pkg::PH_RECV: begin
               shift_in     = recv_shift;
               bit_count_in = bit_next;
               if (bit_next >= i2cm_pkg::BITS_PER_BYTE) begin
                  // First byte is the low byte of the result.
                  if (byte_index_ff == i2cm_pkg::RX_FIRST) begin
                     read_accum_in = {8'd0, recv_shift};
                  end else begin
                     read_accum_in = read_accum_ff | {recv_shift, 8'd0};
                  end
                  phase_in = i2cm_pkg::PH_MACK;
               end
            end
            i2cm_pkg::PH_MACK: begin
               if (operation_ff[0] && (byte_index_ff == i2cm_pkg::RX_FIRST)) begin
                  byte_index_in = i2cm_pkg::RX_SECOND;
                  bit_count_in  = '0;
                  shift_in      = '0;
                  phase_in      = i2cm_pkg::PH_RECV;
               end else begin
                  phase_in = i2cm_pkg::PH_STOP;
               end
            end
            default: begin
               phase_in = i2cm_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Line levels and status for the item at the head of the queue.
   always_comb begin
      result_in.scl        = 1'b1;
      result_in.sda_out    = 1'b1;
      result_in.done_res   = 1'b0;
      result_in.nack_error = 1'b0;
      result_in.read_data  = '0;
      result_in.busy_res   = (phase_in != i2cm_pkg::PH_IDLE);
      if (is_tick) begin
         case (phase_ff)
            i2cm_pkg::PH_START:  result_in.sda_out = 1'b0;
            i2cm_pkg::PH_RSTART: result_in.sda_out = 1'b0;
            i2cm_pkg::PH_SEND:   result_in.sda_out = shift_ff[7];
            i2cm_pkg::PH_MACK: begin
               // Acknowledge the first byte of a word read; otherwise not.
               if (operation_ff[0] && (byte_index_ff == i2cm_pkg::RX_FIRST)) begin
                  result_in.sda_out = 1'b0;
               end
            end
            i2cm_pkg::PH_STOP: begin
               result_in.done_res = 1'b1;
               if (is_read) begin
                  result_in.read_data = read_accum_ff;
               end
            end
            i2cm_pkg::PH_STOP_ERR: begin
               result_in.done_res   = 1'b1;
               result_in.nack_error = 1'b1;
            end
            default: begin
               result_in.sda_out = 1'b1;
            end
         endcase
      end
   end

   // Sequencer state and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         shift_ff      <= shift_in;
         timeout_ff    <= timeout_in;
         read_accum_ff <= read_accum_in;
         operation_ff  <= operation_in;
         device_ff     <= device_in;
         register_ff   <= register_in;
         data_ff       <= data_in;
         result_ff     <= result_in;
      end
   end

endmodule

/* hdl/i2c_master_register_access.sv */
// I2C master for single register transactions (write byte or word, read byte or word)
// to a 7-bit device at a one- or two-byte register address. Send a command request,
// then one tick request per bus phase with the sampled SDA level; every request gives
// exactly one response carrying the SCL and SDA levels for that phase and the status.
// Throughput is one request per clock while the response side is ready, held by the
// sequencer, which performs one bus phase per accepted tick; a request's response
// passes through the request queue and then the response register, and waits longer
// in the queue while the response side stalls. Control registers are written through
// the csr port, which is always ready. Uses i2cm_pkg, i2cm_front and i2cm_back.

module i2c_master_register_access #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [1:0]  req_operation,
   input  logic [6:0]  req_device_address,
   input  logic [15:0] req_register_address,
   input  logic [15:0] req_write_data,
   input  logic        req_sda_in,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_nack_error,
   output logic [15:0] rsp_read_data
);

   logic                      entry_valid;
   logic                      entry_pop;
   i2cm_pkg::queue_entry_type entry;
   i2cm_pkg::result_type      result;

   // Request acceptance, classification and queue.
   i2cm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_operation        (req_operation),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_sda_in           (req_sda_in),
      .entry_valid          (entry_valid),
      .entry_pop            (entry_pop),
      .entry                (entry)
   );

   // Bus phase sequencer and response register.
   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry_pop   (entry_pop),
      .entry       (entry),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .result      (result)
   );

   // Unpack the response onto its ports.
   assign rsp_scl        = result.scl;
   assign rsp_sda_out    = result.sda_out;
   assign rsp_busy_res   = result.busy_res;
   assign rsp_done_res   = result.done_res;
   assign rsp_nack_error = result.nack_error;
   assign rsp_read_data  = result.read_data;

endmodule

/* tb/tb_i2c_master_register_access.sv */
// Self-checking testbench for the I2C register access master: directed requests, then
// random register transactions under several control settings, checked by a bus predictor.
// Depends on i2cm_pkg and the i2c_master_register_access RTL.
`timescale 1ns / 1ps

module tb_i2c_master_register_access;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEMS_PER_SETTING = 85;
   localparam int unsigned SETTING_COUNT = 5;
   localparam int unsigned PRINT_LIMIT = 100;

   // Line levels that can be read off directly.
   localparam i2cm_pkg::result_type IDLE_LEVELS = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000};
   localparam i2cm_pkg::result_type BUSY_LEVELS = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};

   typedef struct {
      i2cm_pkg::queue_entry_type request;
      logic                      typed;
      i2cm_pkg::result_type      typed_result;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [1:0]  req_operation = 2'd0;
   logic [6:0]  req_device_address = 7'd0;
   logic [15:0] req_register_address = 16'd0;
   logic [15:0] req_write_data = 16'd0;
   logic        req_sda_in = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'd0;
   logic [7:0]  csr_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_scl;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_nack_error;
   logic [15:0] rsp_read_data;

   // Predicted bus sequencer state and control registers.
   i2cm_pkg::phase_type bus_phase = i2cm_pkg::PH_IDLE;
   logic [3:0]  bit_total = 4'd0;
   logic [2:0]  byte_slot = 3'd0;
   logic [7:0]  bit_shifter = 8'd0;
   logic [7:0]  ack_wait = 8'd0;
   logic [15:0] received_word = 16'd0;
   logic [1:0]  held_operation = 2'd0;
   logic [6:0]  held_device = 7'd0;
   logic [15:0] held_register = 16'd0;
   logic [15:0] held_data = 16'd0;
   logic [7:0]  ack_limit = i2cm_pkg::ACK_TIMEOUT_RESET;
   logic [1:0]  address_setting = i2cm_pkg::ADDRESS_BYTES_RESET;

   i2cm_pkg::result_type expected_levels[$];
   script_row_type       directed_script[$];
   i2cm_pkg::result_type oldest_levels;
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    burst_left = 0;
   int unsigned    setting_items = 0;
   logic [7:0]     stall_step = 8'd0;

   i2c_master_register_access i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_operation        (req_operation),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_sda_in           (req_sda_in),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scl              (rsp_scl),
      .rsp_sda_out          (rsp_sda_out),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_nack_error       (rsp_nack_error),
      .rsp_read_data        (rsp_read_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The response side stalls on a pattern chosen by the top two bits of a step counter.
   always @(negedge clock) begin
      stall_step <= stall_step + 8'd1;
      case (stall_step[7:6])
         2'd0: begin
            rsp_ready <= 1'b1;
         end
         2'd1: begin
            rsp_ready <= stall_step[0];
         end
         2'd2: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= (stall_step[3:0] < 4'd11);
         end
      endcase
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // Each response is compared with the oldest expected line levels.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_levels = expected_levels.pop_front();
            if (rsp_scl !== oldest_levels.scl)
               report_mismatch($sformatf("scl %b, want %b", rsp_scl, oldest_levels.scl));
            if (rsp_sda_out !== oldest_levels.sda_out)
               report_mismatch($sformatf("sda_out %b, want %b", rsp_sda_out,
                                         oldest_levels.sda_out));
            if (rsp_busy_res !== oldest_levels.busy_res)
               report_mismatch($sformatf("busy_res %b, want %b", rsp_busy_res,
                                         oldest_levels.busy_res));
            if (rsp_done_res !== oldest_levels.done_res)
               report_mismatch($sformatf("done_res %b, want %b", rsp_done_res,
                                         oldest_levels.done_res));
            if (rsp_nack_error !== oldest_levels.nack_error)
               report_mismatch($sformatf("nack_error %b, want %b", rsp_nack_error,
                                         oldest_levels.nack_error));
            if (rsp_read_data !== oldest_levels.read_data)
               report_mismatch($sformatf("read_data %h, want %h", rsp_read_data,
                                         oldest_levels.read_data));
         end
      end
   end

   function automatic logic [2:0] address_byte_count();
      return (address_setting >= 2'd2) ? 3'd2 : 3'd1;
   endfunction

   // Byte at position k of the outgoing sequence: device, register address, then
   // either the read address or the write data, high byte first.
   function automatic logic [7:0] outgoing_byte(input logic [2:0] k);
      logic [2:0] na;
      na = address_byte_count();
      if (k == 3'd0)
         return {held_device, 1'b0};
      if (k <= na)
         return (na == 3'd2 && k == 3'd1) ? held_register[15:8] : held_register[7:0];
      if (held_operation[1])
         return {held_device, 1'b1};
      if (held_operation[0] && k == na + 3'd1)
         return held_data[15:8];
      return held_data[7:0];
   endfunction

   function automatic void load_outgoing(input logic [2:0] k);
      byte_slot = k;
      bit_shifter = outgoing_byte(k);
      bit_total = 4'd0;
      bus_phase = i2cm_pkg::PH_SEND;
   endfunction

   // Advances the predicted bus by one request and returns its line levels.
   function automatic i2cm_pkg::result_type advance_bus(input i2cm_pkg::queue_entry_type rq);
      i2cm_pkg::result_type levels;
      logic [2:0] na;
      logic [2:0] nd;
      levels = IDLE_LEVELS;
      na = address_byte_count();
      nd = held_operation[0] ? 3'd2 : 3'd1;
      if (rq.item_class == i2cm_pkg::ITEM_COMMAND) begin
         // A command is only taken while the bus is idle.
         if (bus_phase == i2cm_pkg::PH_IDLE) begin
            held_operation = rq.operation;
            held_device = rq.device_address;
            held_register = rq.register_address;
            held_data = rq.write_data;
            bit_total = 4'd0;
            byte_slot = 3'd0;
            bit_shifter = 8'd0;
            ack_wait = 8'd0;
            received_word = 16'd0;
            bus_phase = i2cm_pkg::PH_START;
         end
      end else begin
         case (bus_phase)
            i2cm_pkg::PH_START: begin
               levels.sda_out = 1'b0;
               load_outgoing(3'd0);
            end
            i2cm_pkg::PH_SEND: begin
               levels.sda_out = bit_shifter[7];
               bit_shifter = bit_shifter << 1;
               bit_total = bit_total + 4'd1;
               if (bit_total >= i2cm_pkg::BITS_PER_BYTE) begin
                  ack_wait = 8'd0;
                  bus_phase = i2cm_pkg::PH_SACK;
               end
            end
            i2cm_pkg::PH_SACK: begin
               // A released ACK slot is tolerated up to the limit, then aborts.
               if (rq.sda_in) begin
                  if (ack_wait >= ack_limit)
                     bus_phase = i2cm_pkg::PH_STOP_ERR;
                  else
                     ack_wait = ack_wait + 8'd1;
               end else if (held_operation[1]) begin
                  if (byte_slot < na) begin
                     load_outgoing(byte_slot + 3'd1);
                  end else if (byte_slot == na) begin
                     bus_phase = i2cm_pkg::PH_RSTART;
                  end else begin
                     byte_slot = i2cm_pkg::RX_FIRST;
                     bit_total = 4'd0;
                     bit_shifter = 8'd0;
                     bus_phase = i2cm_pkg::PH_RECV;
                  end
               end else if (byte_slot < na + nd) begin
                  load_outgoing(byte_slot + 3'd1);
               end else begin
                  bus_phase = i2cm_pkg::PH_STOP;
               end
            end
            i2cm_pkg::PH_RSTART: begin
               levels.sda_out = 1'b0;
               load_outgoing(na + 3'd1);
            end
            i2cm_pkg::PH_RECV: begin
               bit_shifter = {bit_shifter[6:0], rq.sda_in};
               bit_total = bit_total + 4'd1;
               if (bit_total >= i2cm_pkg::BITS_PER_BYTE) begin
                  if (byte_slot == i2cm_pkg::RX_FIRST)
                     received_word = {8'h00, bit_shifter};
                  else
                     received_word[15:8] = bit_shifter;
                  bus_phase = i2cm_pkg::PH_MACK;
               end
            end
            i2cm_pkg::PH_MACK: begin
               // The master acknowledges the first byte of a word and NACKs the last.
               if (held_operation[0] && byte_slot == i2cm_pkg::RX_FIRST) begin
                  levels.sda_out = 1'b0;
                  byte_slot = i2cm_pkg::RX_SECOND;
                  bit_total = 4'd0;
                  bit_shifter = 8'd0;
                  bus_phase = i2cm_pkg::PH_RECV;
               end else begin
                  bus_phase = i2cm_pkg::PH_STOP;
               end
            end
            i2cm_pkg::PH_STOP: begin
               levels.done_res = 1'b1;
               if (held_operation[1])
                  levels.read_data = received_word;
               bus_phase = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_STOP_ERR: begin
               levels.done_res = 1'b1;
               levels.nack_error = 1'b1;
               bus_phase = i2cm_pkg::PH_IDLE;
            end
            default: begin
               bus_phase = i2cm_pkg::PH_IDLE;
            end
         endcase
      end
      levels.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
      return levels;
   endfunction

   // Sends one request in bursts with random gaps and records what it should produce.
   task automatic send_request(input i2cm_pkg::queue_entry_type rq, input logic typed,
                               input i2cm_pkg::result_type typed_result);
      int unsigned          gap;
      i2cm_pkg::result_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= rq.item_class;
      req_operation <= rq.operation;
      req_device_address <= rq.device_address;
      req_register_address <= rq.register_address;
      req_write_data <= rq.write_data;
      req_sda_in <= rq.sda_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_bus(rq);
      expected_levels.push_back(typed ? typed_result : predicted);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == i2cm_pkg::CSR_ACK_TIMEOUT)
         ack_limit = value;
      else if (index == i2cm_pkg::CSR_ADDRESS_BYTES)
         address_setting = value[1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds off new requests until every expected response has arrived.
   task automatic settle_bus();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input i2cm_pkg::queue_entry_type rq, input logic typed,
                          input i2cm_pkg::result_type typed_result);
      directed_script.push_back('{rq, typed, typed_result});
   endtask

   // Field values that favor the extremes.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic i2cm_pkg::queue_entry_type random_request(
      input i2cm_pkg::item_class_type item_class
   );
      i2cm_pkg::queue_entry_type rq;
      rq.item_class = item_class;
      rq.operation = 2'($urandom);
      rq.device_address = 7'(pick_word());
      rq.register_address = pick_word();
      rq.write_data = pick_word();
      rq.sda_in = 1'($urandom);
      return rq;
   endfunction

   // One complete register transaction with random content, stray requests mixed in.
   task automatic run_transaction();
      i2cm_pkg::queue_entry_type rq;
      logic                      abort_planned;
      send_request(random_request(i2cm_pkg::ITEM_COMMAND), 1'b0, '0);
      setting_items++;
      // Planned aborts only under short timeouts, so the request count stays steady.
      abort_planned = ($urandom_range(0, 5) == 0) && (ack_limit < 8'd16);
      while (bus_phase != i2cm_pkg::PH_IDLE) begin
         // A command during a transaction must be ignored.
         if ($urandom_range(0, 15) == 0)
            send_request(random_request(i2cm_pkg::ITEM_COMMAND), 1'b0, '0);
         rq = random_request(i2cm_pkg::ITEM_TICK);
         if (bus_phase == i2cm_pkg::PH_SACK)
            rq.sda_in = abort_planned || ($urandom_range(0, 7) == 0);
         send_request(rq, 1'b0, '0);
         setting_items++;
      end
      // A tick on an idle bus changes nothing.
      if ($urandom_range(0, 2) == 0)
         send_request(random_request(i2cm_pkg::ITEM_TICK), 1'b0, '0);
   endtask

   initial begin
      logic [7:0]  first_byte;
      logic [7:0]  timeout_value;
      logic [1:0]  address_value;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: immediate abort at the first released ACK slot.
      write_register(i2cm_pkg::CSR_ACK_TIMEOUT, 8'd0);
      write_register(i2cm_pkg::CSR_ADDRESS_BYTES, {6'($urandom), 2'd3});
      add_row({i2cm_pkg::ITEM_TICK, 2'd0, 7'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
              IDLE_LEVELS);
      add_row({i2cm_pkg::ITEM_TICK, 2'd3, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1,
              IDLE_LEVELS);
      add_row({i2cm_pkg::ITEM_COMMAND, 2'd0, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
              BUSY_LEVELS);
      add_row({i2cm_pkg::ITEM_COMMAND, 2'd1, 7'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
              BUSY_LEVELS);
      add_row({i2cm_pkg::ITEM_COMMAND, 2'd2, 7'h55, 16'h1234, 16'hABCD, 1'b1}, 1'b1,
              BUSY_LEVELS);
      add_row({i2cm_pkg::ITEM_COMMAND, 2'd3, 7'h2A, 16'h8001, 16'h7FFE, 1'b0}, 1'b1,
              BUSY_LEVELS);
      add_row({i2cm_pkg::ITEM_TICK, 2'd0, 7'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
              {1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000});
      first_byte = {7'h7F, 1'b0};
      for (int b = 7; b >= 0; b--) begin
         add_row({i2cm_pkg::ITEM_TICK, 2'd0, 7'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
                 {1'b1, first_byte[b], 1'b1, 1'b0, 1'b0, 16'h0000});
      end
      add_row({i2cm_pkg::ITEM_TICK, 2'd0, 7'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
              BUSY_LEVELS);
      add_row({i2cm_pkg::ITEM_TICK, 2'd0, 7'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
              {1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000});
      add_row({i2cm_pkg::ITEM_TICK, 2'd1, 7'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0);
      foreach (directed_script[i]) begin
         send_request(directed_script[i].request, directed_script[i].typed,
                      directed_script[i].typed_result);
      end
      settle_bus();

      // Random transactions under a sequence of control settings.
      for (int unsigned s = 0; s < SETTING_COUNT; s++) begin
         case (s)
            0: begin
               timeout_value = 8'd255;
               address_value = 2'd1;
            end
            1: begin
               timeout_value = 8'd3;
               address_value = 2'd0;
            end
            2: begin
               timeout_value = 8'($urandom_range(4, 250));
               address_value = 2'd2;
            end
            3: begin
               timeout_value = 8'd0;
               address_value = 2'd3;
            end
            default: begin
               timeout_value = 8'($urandom_range(1, 8));
               address_value = 2'($urandom);
            end
         endcase
         write_register(i2cm_pkg::CSR_ACK_TIMEOUT, timeout_value);
         write_register(i2cm_pkg::CSR_ADDRESS_BYTES, {6'($urandom), address_value});
         setting_items = 0;
         while (setting_items < ITEMS_PER_SETTING) run_transaction();
         settle_bus();
      end

      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_register_access.sv
tb/tb_i2c_master_register_access.sv
